// ----- rtl/core/odo_pkg.sv -----
// odo_pkg: shared constants, register codes and arctangent table for the
// differential drive odometry block. No dependencies.
`default_nettype none
package odo_pkg;

  localparam int COUNT_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [31:0] DPP_RESET = 32'd18740337;
  localparam logic [31:0] TPD_RESET = 32'd213045;

  // register index codes (paddr[2])
  localparam logic REG_DPP = 1'b0;
  localparam logic REG_TPD = 1'b1;

  localparam int CORD_W = 33;
  localparam int ANG_W  = 34;
  localparam int IDX_W  = 5;

  localparam logic signed [CORD_W-1:0] CORDIC_START = 33'sd652032874;
  localparam logic signed [31:0]       Q30_ONE      = 32'sd1073741824;

  // arctan(2^-i) in turns scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/differential_drive_odometry.sv -----
// Differential drive odometry, midpoint heading.
// Input channel (in_valid/in_stall): kind, left_count, right_count. kind 1
// clears the pose; kind 0 integrates one encoder tick.
// Result channel (out_valid/out_stall): x_pos, y_pos (Q16.16 cm) and heading
// (binary angle, 2^31 = pi), the pose after the item.
// Config: APB-style port, travel per pulse at 0x0, turn per pulse of
// difference at 0x4; write only while idle.
// One item is in work at a time. An update runs a bit-serial multiply
// (travel and heading change together), a setup state, CORDIC_STAGES
// cordic iterations, a second setup state, a bit-serial multiply for both
// displacements, and a post state that writes the result once the output
// register is free; only then can the next item be accepted. A clear goes
// straight to the post state. The serial multipliers and the single cordic
// set the update time.
// Reset zeroes the pose, loads the register defaults and empties the
// output register. in_stall is high while an item is in work. A finished
// result waits in the output register while out_stall is high; the next
// item may already be accepted and runs until it needs that register.
`default_nettype none
module differential_drive_odometry #(
  parameter int COUNT_BITS    = odo_pkg::COUNT_BITS_DEF,
  parameter int CORDIC_STAGES = odo_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic signed [COUNT_BITS-1:0] in_left_count,
  input  wire logic signed [COUNT_BITS-1:0] in_right_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [31:0]                out_x_pos,
  output logic signed [31:0]                out_y_pos,
  output logic signed [31:0]                out_heading,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DW    = COUNT_BITS + 1;
  localparam int SAW   = COUNT_BITS + 2;
  localparam int SPW   = COUNT_BITS + 16;
  localparam int AAW   = SPW + 1;
  localparam int PW    = SPW + 4;
  localparam int CNT_W = odo_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MID  = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_TRIG = 3'd4;
  localparam logic [2:0] S_ADV  = 3'd5;
  localparam logic [2:0] S_POST = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       dpp_r, tpd_r;
  logic [31:0]       pos_x_r, pos_y_r, yaw_r;
  logic              sneg_r, xneg_r, yneg_r;
  logic              upd_r;
  logic              out_valid_r;
  logic [31:0]       ox_r, oy_r, oh_r;

  logic              accept, cfg_wr, out_free;
  logic signed [DW-1:0] l_ext, r_ext, sum, diff;
  logic [DW-1:0]     smag;
  logic [DW+31:0]    chg_prod;
  logic [SAW+31:0]   stp_prod;
  logic [AAW+31:0]   ax_prod, ay_prod;
  logic [SPW-1:0]    step;
  logic [31:0]       mid, yaw_new;
  logic signed [31:0] cos_q, sin_q;
  logic [31:0]       cmag, smag_t;
  logic [PW-1:0]     dx, dy;
  logic [31:0]       nx, ny;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == odo_pkg::REG_TPD) ? tpd_r : dpp_r;
  assign out_free = !out_valid_r || !out_stall;

  assign l_ext = {in_left_count[COUNT_BITS-1], in_left_count};
  assign r_ext = {in_right_count[COUNT_BITS-1], in_right_count};
  assign sum   = l_ext + r_ext;
  assign diff  = r_ext - l_ext;
  assign smag  = sum[DW-1] ? DW'(-sum) : sum;

  odo_smul #(.AW(DW), .BW(32)) u_chg (
    .clk(clk), .load(accept), .en(state_r == S_MUL),
    .a(diff), .b(tpd_r), .prod(chg_prod)
  );

  odo_smul #(.AW(SAW), .BW(32)) u_step (
    .clk(clk), .load(accept), .en(state_r == S_MUL),
    .a({1'b0, smag}), .b(dpp_r), .prod(stp_prod)
  );

  assign step = stp_prod[SPW+16:17];

  // midpoint heading from the old yaw plus half the change
  assign mid     = yaw_r + chg_prod[32:1];
  assign yaw_new = yaw_r + chg_prod[31:0];

  odo_cordic u_cordic (
    .clk(clk), .load(state_r == S_MID), .en(state_r == S_CORD),
    .angle(mid), .idx(cnt_r), .cos_q(cos_q), .sin_q(sin_q)
  );

  assign cmag   = cos_q[31] ? 32'(-cos_q) : cos_q;
  assign smag_t = sin_q[31] ? 32'(-sin_q) : sin_q;

  odo_smul #(.AW(AAW), .BW(32)) u_advx (
    .clk(clk), .load(state_r == S_TRIG), .en(state_r == S_ADV),
    .a({1'b0, step}), .b(cmag), .prod(ax_prod)
  );

  odo_smul #(.AW(AAW), .BW(32)) u_advy (
    .clk(clk), .load(state_r == S_TRIG), .en(state_r == S_ADV),
    .a({1'b0, step}), .b(smag_t), .prod(ay_prod)
  );

  assign dx = {1'b0, ax_prod[AAW+31:30]};
  assign dy = {1'b0, ay_prod[AAW+31:30]};

  function automatic logic [31:0] sat_add(input logic [31:0] pos, input logic [PW-1:0] d,
                                          input logic neg);
    logic signed [PW-1:0] p;
    p = $signed({{(PW-32){pos[31]}}, pos}) + (neg ? -$signed(d) : $signed(d));
    if (p > $signed(PW'(32'h7fff_ffff)))
      return 32'h7fff_ffff;
    else if (p < -$signed(PW'(33'h0_8000_0000)))
      return 32'h8000_0000;
    else
      return p[31:0];
  endfunction

  assign nx = sat_add(pos_x_r, dx, xneg_r);
  assign ny = sat_add(pos_y_r, dy, yneg_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) state_nxt = in_kind ? S_POST : S_MUL;
      end
      S_MUL: if (cnt_r == '1) state_nxt = S_MID;
      S_MID: cnt_nxt = '0;
      S_CORD: if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) state_nxt = S_TRIG;
      S_TRIG: cnt_nxt = '0;
      S_ADV: if (cnt_r == '1) state_nxt = S_POST;
      S_POST: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_MID) state_nxt = S_CORD;
    if (state_r == S_TRIG) state_nxt = S_ADV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dpp_r       <= odo_pkg::DPP_RESET;
      tpd_r       <= odo_pkg::TPD_RESET;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr) begin
        if (paddr[2] == odo_pkg::REG_TPD) tpd_r <= pwdata;
        else                              dpp_r <= pwdata;
      end
      if (accept && in_kind) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        yaw_r   <= '0;
      end
      if (accept) begin
        sneg_r <= sum[DW-1];
        upd_r  <= !in_kind;
      end
      if (state_r == S_TRIG) begin
        xneg_r <= sneg_r ^ cos_q[31];
        yneg_r <= sneg_r ^ sin_q[31];
      end
      // displacement products are complete once the post state is reached
      if (state_r == S_POST && out_free && upd_r) begin
        pos_x_r <= nx;
        pos_y_r <= ny;
        yaw_r   <= yaw_new;
      end
      if (state_r == S_POST && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_POST && out_free) begin
      ox_r <= upd_r ? nx : pos_x_r;
      oy_r <= upd_r ? ny : pos_y_r;
      oh_r <= upd_r ? yaw_new : yaw_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_pos   = ox_r;
  assign out_y_pos   = oy_r;
  assign out_heading = oh_r;

endmodule
`default_nettype wire

// ----- rtl/core/odo_smul.sv -----
// odo_smul: bit-serial shift-add multiplier, signed multiplicand by unsigned
// multiplier, one multiplier bit per cycle while en is high. Uses no package items.
`default_nettype none
module odo_smul #(
  parameter int AW = 18,
  parameter int BW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [BW-1:0]        b,
  output logic [AW+BW-1:0]          prod
);

  logic signed [AW-1:0] a_r, acc_r;
  logic [BW-1:0]        b_r, low_r;
  logic signed [AW:0]   sum;

  // partial sum halves each cycle while en is high, dropped bit shifts into the low word
  assign sum = {acc_r[AW-1], acc_r} + (b_r[0] ? {a_r[AW-1], a_r} : '0);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      low_r <= '0;
    end else if (en) begin
      acc_r <= sum[AW:1];
      low_r <= {sum[0], low_r[BW-1:1]};
      b_r   <= b_r >> 1;
    end
  end

  assign prod = {acc_r, low_r};

endmodule
`default_nettype wire

// ----- rtl/core/odo_cordic.sv -----
// odo_cordic: iterative rotation-mode cordic, one iteration per cycle while en is high,
// giving clamped Q2.30 cosine and sine. Depends on odo_pkg.
`default_nettype none
module odo_cordic (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic                          en,
  input  wire logic [31:0]                   angle,
  input  wire logic [odo_pkg::IDX_W-1:0]     idx,
  output logic signed [31:0]                 cos_q,
  output logic signed [31:0]                 sin_q
);

  logic signed [odo_pkg::CORD_W-1:0] x_r, y_r, dx, dy, xf, yf;
  logic signed [odo_pkg::ANG_W-1:0]  z_r, at;
  logic                              flip_r;
  logic                              flip;
  logic [31:0]                       ang2, at_u;

  function automatic logic ang2_msb(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h4000_0000;
    return t[31];
  endfunction

  // fold the left half plane onto the right one
  assign flip = ang2_msb(angle);
  assign ang2 = flip ? angle + 32'h8000_0000 : angle;
  assign at_u = odo_pkg::atan_turns(idx);
  assign at   = {{(odo_pkg::ANG_W-32){1'b0}}, at_u};
  assign dx   = y_r >>> idx;
  assign dy   = x_r >>> idx;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= odo_pkg::CORDIC_START;
      y_r    <= '0;
      z_r    <= {{(odo_pkg::ANG_W-32){ang2[31]}}, ang2};
      flip_r <= flip;
    end else if (en) begin
      if (!z_r[odo_pkg::ANG_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;

  always_comb begin
    if (xf > 33'(odo_pkg::Q30_ONE))       cos_q = odo_pkg::Q30_ONE;
    else if (xf < -33'(odo_pkg::Q30_ONE)) cos_q = -odo_pkg::Q30_ONE;
    else                                  cos_q = xf[31:0];
    if (yf > 33'(odo_pkg::Q30_ONE))       sin_q = odo_pkg::Q30_ONE;
    else if (yf < -33'(odo_pkg::Q30_ONE)) sin_q = -odo_pkg::Q30_ONE;
    else                                  sin_q = yf[31:0];
  end

endmodule
`default_nettype wire

// ----- rtl/core/odo_check.sv -----
// odo_check: port-level checks for differential_drive_odometry, attached by
// bind. No package dependencies.
`default_nettype none
module odo_check (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_kind,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [31:0]           out_x_pos,
  input wire logic [31:0]           out_y_pos,
  input wire logic [31:0]           out_heading,
  input wire logic                  pready
);

  // a stalled result holds its valid, heading and x position
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_heading) && $stable(out_x_pos))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // a clear item accepted while the output is empty reports the zero pose
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind && !out_valid |=> ##1
      (out_valid && out_x_pos == 32'd0 && out_y_pos == 32'd0 && out_heading == 32'd0))
    else $error("clear did not zero pose");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind differential_drive_odometry odo_check u_odo_check (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
  .out_valid(out_valid), .out_stall(out_stall), .out_x_pos(out_x_pos),
  .out_y_pos(out_y_pos), .out_heading(out_heading), .pready(pready)
);
`default_nettype wire
